// File: rtl/acbc_pkg.sv
`default_nettype none
package acbc_pkg;

   localparam int NumRounds = 10;

   typedef logic [7:0] sbox_table_type [256];
   typedef logic [NumRounds:0][127:0] round_keys_type;

   typedef enum logic [1:0] {
      REG_KEY_HIGH = 2'd0,
      REG_KEY_LOW  = 2'd1,
      REG_IV_HIGH  = 2'd2,
      REG_IV_LOW   = 2'd3
   } reg_index_type;

   localparam logic [7:0] RCON [NumRounds] = '{
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
   };

   // GF(2^8) multiply, AES polynomial
   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] r;
      logic [7:0] x;
      logic [7:0] y;
      r = 8'h00;
      x = a;
      y = b;
      for (int i = 0; i < 8; i++) begin
         if (y[0]) r = r ^ x;
         x = x[7] ? ({x[6:0], 1'b0} ^ 8'h1b) : {x[6:0], 1'b0};
         y = {1'b0, y[7:1]};
      end
      return r;
   endfunction

   function automatic logic [7:0] ginv(input logic [7:0] x);
      logic [7:0] r;
      logic [7:0] p;
      logic [7:0] e;
      r = 8'h01;
      p = x;
      e = 8'd254;
      for (int i = 0; i < 8; i++) begin
         if (e[i]) r = gmul(r, p);
         p = gmul(p, p);
      end
      return r;
   endfunction

   function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
      logic [15:0] d;
      d = {x, x} << n;
      return d[15:8];
   endfunction

   function automatic sbox_table_type build_sbox();
      sbox_table_type t;
      logic [7:0] b;
      for (int i = 0; i < 256; i++) begin
         b = ginv(8'(i));
         t[i] = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
      end
      return t;
   endfunction

   function automatic sbox_table_type build_inv_sbox(input sbox_table_type fwd);
      sbox_table_type t;
      for (int i = 0; i < 256; i++) begin
         t[fwd[i]] = 8'(i);
      end
      return t;
   endfunction

   localparam sbox_table_type SBOX = build_sbox();
   localparam sbox_table_type INV_SBOX = build_inv_sbox(SBOX);

   // byte i of a block sits at bits [127-8*i -: 8]
   function automatic logic [127:0] sub_bytes(input logic [127:0] s);
      logic [127:0] t;
      for (int i = 0; i < 16; i++) begin
         t[127-8*i -: 8] = SBOX[s[127-8*i -: 8]];
      end
      return t;
   endfunction

   function automatic logic [127:0] inv_sub_bytes(input logic [127:0] s);
      logic [127:0] t;
      for (int i = 0; i < 16; i++) begin
         t[127-8*i -: 8] = INV_SBOX[s[127-8*i -: 8]];
      end
      return t;
   endfunction

   function automatic logic [127:0] shift_rows(input logic [127:0] s);
      logic [127:0] t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127-8*(r+4*c) -: 8] = s[127-8*(r+4*((c+r)&3)) -: 8];
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] inv_shift_rows(input logic [127:0] s);
      logic [127:0] t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127-8*(r+4*((c+r)&3)) -: 8] = s[127-8*(r+4*c) -: 8];
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] mix_columns(input logic [127:0] s,
                                                input logic [7:0] m0, input logic [7:0] m1,
                                                input logic [7:0] m2, input logic [7:0] m3);
      logic [127:0] t;
      logic [7:0] a [4];
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) a[r] = s[127-8*(4*c+r) -: 8];
         for (int r = 0; r < 4; r++) begin
            t[127-8*(4*c+r) -: 8] = gmul(a[r], m0) ^ gmul(a[(r+1)&3], m1) ^
                                    gmul(a[(r+2)&3], m2) ^ gmul(a[(r+3)&3], m3);
         end
      end
      return t;
   endfunction

endpackage
`default_nettype wire

// File: rtl/acbc_req_if.sv
`default_nettype none
interface acbc_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [63:0] block_high;
   logic [63:0] block_low;
   logic        restart;
   logic        final_block;

   modport source (output valid, req_type, block_high, block_low, restart, final_block,
                   input ready);
   modport sink (input valid, req_type, block_high, block_low, restart, final_block,
                 output ready);
endinterface
`default_nettype wire

// File: rtl/acbc_rsp_if.sv
`default_nettype none
interface acbc_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] out_high;
   logic [63:0] out_low;

   modport source (output valid, out_high, out_low, input ready);
   modport sink (input valid, out_high, out_low, output ready);
endinterface
`default_nettype wire

// File: rtl/acbc_key_sched.sv
`default_nettype none
module acbc_key_sched
   import acbc_pkg::*;
(
   input  wire logic [127:0]   key,
   output round_keys_type      round_keys
);

   assign round_keys[0] = key;

   for (genvar k = 1; k <= NumRounds; k++) begin : g_round
      logic [31:0] w3;
      logic [31:0] t;
      logic [127:0] p;
      logic [31:0] n0, n1, n2, n3;

      assign p  = round_keys[k-1];
      assign w3 = p[31:0];
      // rotate, substitute, add round constant
      assign t  = {SBOX[w3[23:16]] ^ RCON[k-1], SBOX[w3[15:8]], SBOX[w3[7:0]],
                   SBOX[w3[31:24]]};
      assign n0 = p[127:96] ^ t;
      assign n1 = p[95:64] ^ n0;
      assign n2 = p[63:32] ^ n1;
      assign n3 = p[31:0] ^ n2;
      assign round_keys[k] = {n0, n1, n2, n3};
   end

endmodule
`default_nettype wire

// File: rtl/acbc_cipher.sv
`default_nettype none
module acbc_cipher
   import acbc_pkg::*;
(
   input  wire round_keys_type round_keys,
   input  wire logic [127:0]   enc_in,
   input  wire logic [127:0]   dec_in,
   output logic [127:0]        enc_out,
   output logic [127:0]        dec_out
);

   logic [NumRounds:0][127:0] enc_st;
   logic [NumRounds:0][127:0] dec_st;

   assign enc_st[0] = enc_in ^ round_keys[0];
   assign dec_st[0] = dec_in ^ round_keys[NumRounds];

   for (genvar r = 1; r <= NumRounds; r++) begin : g_round
      logic [127:0] fs;
      logic [127:0] is;
      assign fs = shift_rows(sub_bytes(enc_st[r-1]));
      assign is = inv_sub_bytes(inv_shift_rows(dec_st[r-1])) ^ round_keys[NumRounds-r];
      if (r == NumRounds) begin : g_last
         assign enc_st[r] = fs ^ round_keys[r];
         assign dec_st[r] = is;
      end else begin : g_mid
         assign enc_st[r] = mix_columns(fs, 8'd2, 8'd3, 8'd1, 8'd1) ^ round_keys[r];
         assign dec_st[r] = mix_columns(is, 8'd14, 8'd11, 8'd13, 8'd9);
      end
   end

   assign enc_out = enc_st[NumRounds];
   assign dec_out = dec_st[NumRounds];

endmodule
`default_nettype wire

// File: rtl/aes128_cbc_block_cipher_core.sv
`default_nettype none
// AES-128 in CBC mode, one 128-bit block per beat in each direction. A request beat
// carries an encrypt/decrypt flag, the block, a restart flag (load both chains from
// the IV before the block) and a final flag (zero both chains after the block).
// A beat lands in the input stage register; the complete key schedule, all ten
// rounds and the chain XOR run in one combinational pass from that register into
// the result register, and a new beat is taken every cycle while the result side
// keeps draining. The one-cycle rate is set by the chain registers, which update
// as a block moves to the result register and feed the very next block. Key and
// IV live in four 64-bit registers on the APB port at byte addresses 0, 8, 16 and
// 24 (key high, key low, IV high, IV low); write them only while no block is in
// flight. Byte 0 of a block or key is bits 63:56 of its high half.
module aes128_cbc_block_cipher_core
   import acbc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   acbc_req_if.sink         req_chan,
   acbc_rsp_if.source       rsp_chan,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output logic [63:0]      csr_prdata,
   output logic             csr_pready
);

   // configuration registers
   logic [63:0] key_high_ff, key_high_in;
   logic [63:0] key_low_ff, key_low_in;
   logic [63:0] iv_high_ff, iv_high_in;
   logic [63:0] iv_low_ff, iv_low_in;

   // chain state
   logic [127:0] enc_chain_ff, enc_chain_in;
   logic [127:0] dec_chain_ff, dec_chain_in;

   // input stage
   logic         stage_valid_ff, stage_valid_in;
   logic         stage_type_ff, stage_type_in;
   logic [127:0] stage_block_ff, stage_block_in;
   logic         stage_restart_ff, stage_restart_in;
   logic         stage_final_ff, stage_final_in;

   // result stage
   logic         rsp_valid_ff, rsp_valid_in;
   logic [127:0] rsp_data_ff, rsp_data_in;

   reg_index_type csr_index;
   logic          csr_write;
   logic          req_accept;
   logic          advance;
   logic [127:0]  enc_use;
   logic [127:0]  dec_use;
   logic [127:0]  enc_out;
   logic [127:0]  dec_out;
   logic [127:0]  result;
   round_keys_type round_keys;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[4:3]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_index)
         REG_KEY_HIGH: csr_prdata = key_high_ff;
         REG_KEY_LOW:  csr_prdata = key_low_ff;
         REG_IV_HIGH:  csr_prdata = iv_high_ff;
         REG_IV_LOW:   csr_prdata = iv_low_ff;
         default:      csr_prdata = '0;
      endcase
   end

   always_comb begin
      key_high_in = key_high_ff;
      key_low_in  = key_low_ff;
      iv_high_in  = iv_high_ff;
      iv_low_in   = iv_low_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_KEY_HIGH: key_high_in = csr_pwdata;
            REG_KEY_LOW:  key_low_in  = csr_pwdata;
            REG_IV_HIGH:  iv_high_in  = csr_pwdata;
            REG_IV_LOW:   iv_low_in   = csr_pwdata;
            default:      key_high_in = key_high_ff;
         endcase
      end
   end

   // ---------------- handshake ----------------
   // move the staged block on whenever the result register is free or draining
   assign advance        = stage_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !stage_valid_ff || advance;
   assign req_accept     = req_chan.valid && req_chan.ready;

   always_comb begin
      stage_valid_in   = stage_valid_ff;
      stage_type_in    = stage_type_ff;
      stage_block_in   = stage_block_ff;
      stage_restart_in = stage_restart_ff;
      stage_final_in   = stage_final_ff;
      if (req_accept) begin
         stage_valid_in   = 1'b1;
         stage_type_in    = req_chan.req_type;
         stage_block_in   = {req_chan.block_high, req_chan.block_low};
         stage_restart_in = req_chan.restart;
         stage_final_in   = req_chan.final_block;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
   end

   // ---------------- datapath ----------------
   acbc_key_sched u_key_sched (
      .key        ({key_high_ff, key_low_ff}),
      .round_keys (round_keys)
   );

   // restart swaps in the IV for both chains before the block
   assign enc_use = stage_restart_ff ? {iv_high_ff, iv_low_ff} : enc_chain_ff;
   assign dec_use = stage_restart_ff ? {iv_high_ff, iv_low_ff} : dec_chain_ff;

   acbc_cipher u_cipher (
      .round_keys (round_keys),
      .enc_in     (stage_block_ff ^ enc_use),
      .dec_in     (stage_block_ff),
      .enc_out    (enc_out),
      .dec_out    (dec_out)
   );

   assign result = stage_type_ff ? (dec_out ^ dec_use) : enc_out;

   always_comb begin
      enc_chain_in = enc_chain_ff;
      dec_chain_in = dec_chain_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
         if (stage_final_ff) begin
            // drop both chains after the last block
            enc_chain_in = '0;
            dec_chain_in = '0;
         end else if (stage_type_ff) begin
            enc_chain_in = enc_use;
            dec_chain_in = stage_block_ff;
         end else begin
            enc_chain_in = enc_out;
            dec_chain_in = dec_use;
         end
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff    <= '0;
         key_low_ff     <= '0;
         iv_high_ff     <= '0;
         iv_low_ff      <= '0;
         enc_chain_ff   <= '0;
         dec_chain_ff   <= '0;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         key_high_ff    <= key_high_in;
         key_low_ff     <= key_low_in;
         iv_high_ff     <= iv_high_in;
         iv_low_ff      <= iv_low_in;
         enc_chain_ff   <= enc_chain_in;
         dec_chain_ff   <= dec_chain_in;
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      stage_type_ff    <= stage_type_in;
      stage_block_ff   <= stage_block_in;
      stage_restart_ff <= stage_restart_in;
      stage_final_ff   <= stage_final_in;
      rsp_data_ff      <= rsp_data_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_high = rsp_data_ff[127:64];
   assign rsp_chan.out_low  = rsp_data_ff[63:0];

`ifndef NO_ASSERTIONS
   // a final block leaves both chains cleared
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      advance && stage_final_ff |=> enc_chain_ff == '0 && dec_chain_ff == '0)
      else $error("chains not cleared after final block");

   // an encrypted block becomes the next encrypt chain
   a_enc_chain: assert property (@(posedge clock) disable iff (reset)
      advance && !stage_final_ff && !stage_type_ff |=> enc_chain_ff == rsp_data_ff)
      else $error("encrypt chain does not follow ciphertext");

   // a full stage behind a stalled result must back-pressure the request side
   a_stall: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && rsp_valid_ff && !rsp_chan.ready |-> !req_chan.ready)
      else $error("request taken while pipeline is stalled");
`endif

endmodule
`default_nettype wire
